@@ rtl/core/particle_repulsion_step_defines.svh @@
// ----------------------------------------------------------------------------
// particle_repulsion_step defines
// assertion macros used by the checker of the particle field block
// ----------------------------------------------------------------------------
`ifndef PARTICLE_REPULSION_STEP_DEFINES_SVH
`define PARTICLE_REPULSION_STEP_DEFINES_SVH

// concurrent check, quiet while reset is high
`define PRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("prs check failed");

// concurrent check that also looks at reset cycles
`define PRS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("prs reset check failed");

`endif

@@ rtl/core/prs_pkg.sv @@
// ----------------------------------------------------------------------------
// prs_pkg
// types, constants and helpers of the particle repulsion block
// ----------------------------------------------------------------------------
package prs_pkg;

  localparam int COUNT     = 32;
  localparam int FRAC_BITS = 12;

  localparam int IDX_W     = $clog2(COUNT);
  localparam int SLOT_W    = 6;
  localparam int POS_W     = 24;
  localparam int VEL_W     = 19;
  localparam int GAIN_W    = 16;
  localparam int RAD_W     = 8;
  localparam int BND_W     = 12;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam int RL_W      = RAD_W + FRAC_BITS;
  localparam int D2_W      = 2 * RL_W;
  localparam int SQ_STEPS  = RL_W;
  localparam int K_W       = $clog2(SQ_STEPS);
  localparam int DIV_SH    = GAIN_W - FRAC_BITS;
  localparam int NUM_W     = RL_W + GAIN_W;
  localparam int DVD_W     = NUM_W - DIV_SH;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int B_W       = $clog2(Q_W);
  localparam int TW        = RL_W + Q_W;
  localparam int F_W       = Q_W + IDX_W + 1;
  localparam int SUM_W     = ((VEL_W > F_W) ? VEL_W : F_W) + 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRICTION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd4;

  localparam logic [GAIN_W-1:0] FRICTION_RST = 16'd63570;
  localparam logic [RAD_W-1:0]  RADIUS_RST   = 8'd25;
  localparam logic [GAIN_W-1:0] REPEL_RST    = 16'd197;
  localparam logic [BND_W-1:0]  WIDTH_RST    = 12'd1024;
  localparam logic [BND_W-1:0]  HEIGHT_RST   = 12'd768;

  localparam logic req_write = 1'b0;

  typedef struct packed {
    logic [POS_W-1:0]        px;
    logic [POS_W-1:0]        py;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
  } particle_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SELF_RD, ST_SELF_CAP, ST_NB_RD, ST_NB_DIFF, ST_NB_SQ, ST_NB_TEST,
    ST_SQRT, ST_MULG, ST_DIV, ST_ACC, ST_NB_NEXT, ST_FRIC, ST_VEL, ST_UPD
  } st_t;

  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  function automatic logic signed [VEL_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(VEL_MAX);
    lo = SUM_W'(VEL_MIN);
    if (v > hi) return VEL_MAX;
    else if (v < lo) return VEL_MIN;
    else return v[VEL_W-1:0];
  endfunction

  function automatic logic signed [VEL_W-1:0] sat_neg(input logic signed [VEL_W-1:0] v);
    if (v == VEL_MIN) return VEL_MAX;
    else return -v;
  endfunction

endpackage

@@ rtl/core/prs_ram.sv @@
// ----------------------------------------------------------------------------
// prs_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module prs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/particle_repulsion_step.sv @@
// ----------------------------------------------------------------------------
// particle_repulsion_step
// short range repulsion update of a particle field held in one ram
// ----------------------------------------------------------------------------
// write item: stored at its slot while idle, no result; slots of COUNT and above are ignored
// tick item: per particle a self read, a pass over all COUNT neighbors, then friction,
//   velocity and the update, which waits out output stalls; every neighbor is read, diffed,
//   squared and tested, one in range then runs the sqrt and divide iterations, which dominate
// reset: registers to their defaults, all particles read as zero until written
module particle_repulsion_step (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [prs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [prs_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 req_type,
  input  logic [prs_pkg::SLOT_W-1:0]           slot,
  input  logic [prs_pkg::POS_W-1:0]            in_pos_x,
  input  logic [prs_pkg::POS_W-1:0]            in_pos_y,
  input  logic signed [prs_pkg::VEL_W-1:0]     in_vel_x,
  input  logic signed [prs_pkg::VEL_W-1:0]     in_vel_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [prs_pkg::SLOT_W-1:0]           out_slot,
  output logic [prs_pkg::POS_W-1:0]            out_pos_x,
  output logic [prs_pkg::POS_W-1:0]            out_pos_y,
  output logic signed [prs_pkg::VEL_W-1:0]     out_vel_x,
  output logic signed [prs_pkg::VEL_W-1:0]     out_vel_y,
  output logic                                 last_of_tick
);
  import prs_pkg::*;

  // configuration registers
  logic [GAIN_W-1:0] friction_gain;
  logic [RAD_W-1:0]  repel_radius;
  logic [GAIN_W-1:0] repel_gain;
  logic [BND_W-1:0]  field_width;
  logic [BND_W-1:0]  field_height;
  logic [D2_W-1:0]   r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      friction_gain <= FRICTION_RST;
      repel_radius  <= RADIUS_RST;
      repel_gain    <= REPEL_RST;
      field_width   <= WIDTH_RST;
      field_height  <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRICTION: friction_gain <= cfg_data[GAIN_W-1:0];
        CFG_RADIUS:   repel_radius  <= cfg_data[RAD_W-1:0];
        CFG_REPEL:    repel_gain    <= cfg_data[GAIN_W-1:0];
        CFG_WIDTH:    field_width   <= cfg_data[BND_W-1:0];
        CFG_HEIGHT:   field_height  <= cfg_data[BND_W-1:0];
        default: ;
      endcase
    end
  end

  // squared radius, settles long before a tick needs it
  always_ff @(posedge clk) begin
    r2 <= {(2*RAD_W)'(repel_radius) * (2*RAD_W)'(repel_radius), {(2*FRAC_BITS){1'b0}}};
  end

  // particle store
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  particle_t             ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  particle_t             ram_rdata;
  logic [COUNT-1:0]      vld;
  logic                  rd_vld;
  particle_t             rd_part;

  prs_ram #(
    .WIDTH($bits(particle_t)),
    .DEPTH(COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= vld[ram_raddr];
      if (ram_we) begin
        vld[ram_waddr] <= 1'b1;
      end
    end
  end

  assign rd_part = rd_vld ? ram_rdata : '0;

  // sequencer
  st_t state, state_next;
  logic [IDX_W-1:0] i_idx;
  logic [IDX_W-1:0] j_idx;
  logic             in_acc;
  logic             wr_item;
  logic             out_free;
  logic             upd_go;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign wr_item  = in_acc && (req_type == req_write) && ((SLOT_W+1)'(slot) < (SLOT_W+1)'(COUNT));
  assign out_free = !out_valid || !out_stall;

  // datapath registers
  particle_t               self_p;
  logic                    dx_neg, dy_neg;
  logic [POS_W-1:0]        ax, ay;
  logic [2*POS_W-1:0]      sqx, sqy;
  logic [D2_W-1:0]         sq_rem;
  logic [D2_W-1:0]         root;
  logic [K_W-1:0]          k_cnt;
  logic [DVD_W-1:0]        remx, remy;
  logic [Q_W-1:0]          qx, qy;
  logic [B_W-1:0]          b_cnt;
  logic signed [F_W-1:0]   fx, fy;
  logic signed [VEL_W:0]   fricx, fricy;
  logic signed [VEL_W-1:0] vx_new, vy_new;

  // combinational helpers
  logic [2*POS_W:0]        d2;
  logic                    in_range;
  logic [D2_W-1:0]         sq_bit;
  logic [D2_W:0]           sq_trial;
  logic                    sq_take;
  logic [RL_W-1:0]         d_root;
  logic [TW-1:0]           dv_trial;
  logic                    takex, takey;
  logic signed [POS_W:0]   dxs, dys;
  logic [VEL_W-1:0]        magx, magy;
  logic [VEL_W+GAIN_W-1:0] fpx, fpy;
  logic signed [POS_W+1:0] pxs, pys;
  logic signed [POS_W+1:0] limx, limy;
  logic [POS_W-1:0]        px_fin, py_fin;
  logic signed [VEL_W-1:0] vx_fin, vy_fin;

  assign d2       = (2*POS_W+1)'(sqx) + (2*POS_W+1)'(sqy);
  assign in_range = (d2 != '0) && (d2 < (2*POS_W+1)'(r2));
  assign sq_bit   = D2_W'(1) << {k_cnt, 1'b0};
  assign sq_trial = {1'b0, root} + {1'b0, sq_bit};
  assign sq_take  = {1'b0, sq_rem} >= sq_trial;
  assign d_root   = root[RL_W-1:0];
  assign dv_trial = TW'(d_root) << b_cnt;
  assign takex    = TW'(remx) >= dv_trial;
  assign takey    = TW'(remy) >= dv_trial;
  assign dxs      = $signed({1'b0, rd_part.px}) - $signed({1'b0, self_p.px});
  assign dys      = $signed({1'b0, rd_part.py}) - $signed({1'b0, self_p.py});

  // friction on magnitude, truncation toward zero
  assign magx = self_p.vx[VEL_W-1] ? VEL_W'(-(VEL_W+1)'(self_p.vx)) : VEL_W'(self_p.vx);
  assign magy = self_p.vy[VEL_W-1] ? VEL_W'(-(VEL_W+1)'(self_p.vy)) : VEL_W'(self_p.vy);
  assign fpx  = (VEL_W+GAIN_W)'(magx) * (VEL_W+GAIN_W)'(friction_gain);
  assign fpy  = (VEL_W+GAIN_W)'(magy) * (VEL_W+GAIN_W)'(friction_gain);

  // move and bounce
  assign pxs  = $signed({2'b00, self_p.px}) + (POS_W+2)'(vx_new);
  assign pys  = $signed({2'b00, self_p.py}) + (POS_W+2)'(vy_new);
  assign limx = $signed((POS_W+2)'({field_width, {FRAC_BITS{1'b0}}}));
  assign limy = $signed((POS_W+2)'({field_height, {FRAC_BITS{1'b0}}}));

  always_comb begin
    if (pxs > limx) begin
      px_fin = limx[POS_W-1:0];
      vx_fin = sat_neg(vx_new);
    end else if (pxs < 0) begin
      px_fin = '0;
      vx_fin = sat_neg(vx_new);
    end else begin
      px_fin = pxs[POS_W-1:0];
      vx_fin = vx_new;
    end
    if (pys > limy) begin
      py_fin = limy[POS_W-1:0];
      vy_fin = sat_neg(vy_new);
    end else if (pys < 0) begin
      py_fin = '0;
      vy_fin = sat_neg(vy_new);
    end else begin
      py_fin = pys[POS_W-1:0];
      vy_fin = vy_new;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and store port control
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = i_idx;
    ram_wdata  = '{px: px_fin, py: py_fin, vx: vx_fin, vy: vy_fin};
    ram_raddr  = j_idx;
    upd_go     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (wr_item) begin
          ram_we    = 1'b1;
          ram_waddr = slot[IDX_W-1:0];
          ram_wdata = '{px: in_pos_x, py: in_pos_y, vx: in_vel_x, vy: in_vel_y};
        end
        if (in_acc && (req_type != req_write)) begin
          state_next = ST_SELF_RD;
        end
      end
      ST_SELF_RD: begin
        ram_raddr  = i_idx;
        state_next = ST_SELF_CAP;
      end
      ST_SELF_CAP: state_next = ST_NB_RD;
      ST_NB_RD:    state_next = ST_NB_DIFF;
      ST_NB_DIFF:  state_next = ST_NB_SQ;
      ST_NB_SQ:    state_next = ST_NB_TEST;
      ST_NB_TEST:  state_next = in_range ? ST_SQRT : ST_NB_NEXT;
      ST_SQRT:     state_next = (k_cnt == '0) ? ST_MULG : ST_SQRT;
      ST_MULG:     state_next = ST_DIV;
      ST_DIV:      state_next = (b_cnt == '0) ? ST_ACC : ST_DIV;
      ST_ACC:      state_next = ST_NB_NEXT;
      ST_NB_NEXT:  state_next = (j_idx == IDX_W'(COUNT-1)) ? ST_FRIC : ST_NB_RD;
      ST_FRIC:     state_next = ST_VEL;
      ST_VEL:      state_next = ST_UPD;
      ST_UPD: begin
        if (out_free) begin
          upd_go     = 1'b1;
          ram_we     = 1'b1;
          state_next = (i_idx == IDX_W'(COUNT-1)) ? ST_IDLE : ST_SELF_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // indices
  always_ff @(posedge clk) begin
    if (rst) begin
      i_idx <= '0;
      j_idx <= '0;
    end else begin
      if (state == ST_IDLE) begin
        i_idx <= '0;
      end else if (upd_go) begin
        i_idx <= i_idx + 1'b1;
      end
      if (state == ST_SELF_CAP) begin
        j_idx <= '0;
      end else if (state == ST_NB_NEXT) begin
        j_idx <= j_idx + 1'b1;
      end
    end
  end

  // pair and particle datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_SELF_CAP: begin
        self_p <= rd_part;
        fx     <= '0;
        fy     <= '0;
      end
      ST_NB_DIFF: begin
        dx_neg <= dxs[POS_W];
        dy_neg <= dys[POS_W];
        ax     <= dxs[POS_W] ? POS_W'(-dxs) : POS_W'(dxs);
        ay     <= dys[POS_W] ? POS_W'(-dys) : POS_W'(dys);
      end
      ST_NB_SQ: begin
        sqx <= (2*POS_W)'(ax) * (2*POS_W)'(ax);
        sqy <= (2*POS_W)'(ay) * (2*POS_W)'(ay);
      end
      ST_NB_TEST: begin
        sq_rem <= d2[D2_W-1:0];
        root   <= '0;
        k_cnt  <= K_W'(SQ_STEPS-1);
      end
      ST_SQRT: begin
        if (sq_take) begin
          sq_rem <= sq_rem - sq_trial[D2_W-1:0];
          root   <= (root >> 1) + sq_bit;
        end else begin
          root   <= root >> 1;
        end
        k_cnt <= k_cnt - 1'b1;
      end
      ST_MULG: begin
        // in range, so each offset is below the radius
        remx  <= DVD_W'((NUM_W'(ax[RL_W-1:0]) * NUM_W'(repel_gain)) >> DIV_SH);
        remy  <= DVD_W'((NUM_W'(ay[RL_W-1:0]) * NUM_W'(repel_gain)) >> DIV_SH);
        qx    <= '0;
        qy    <= '0;
        b_cnt <= B_W'(Q_W-1);
      end
      ST_DIV: begin
        if (takex) begin
          remx        <= DVD_W'(TW'(remx) - dv_trial);
          qx[b_cnt]   <= 1'b1;
        end
        if (takey) begin
          remy        <= DVD_W'(TW'(remy) - dv_trial);
          qy[b_cnt]   <= 1'b1;
        end
        b_cnt <= b_cnt - 1'b1;
      end
      ST_ACC: begin
        // push points away from the neighbor
        fx <= dx_neg ? fx + F_W'(qx) : fx - F_W'(qx);
        fy <= dy_neg ? fy + F_W'(qy) : fy - F_W'(qy);
      end
      ST_FRIC: begin
        fricx <= self_p.vx[VEL_W-1] ? -(VEL_W+1)'(fpx[VEL_W+GAIN_W-1:GAIN_W])
                                    :  (VEL_W+1)'(fpx[VEL_W+GAIN_W-1:GAIN_W]);
        fricy <= self_p.vy[VEL_W-1] ? -(VEL_W+1)'(fpy[VEL_W+GAIN_W-1:GAIN_W])
                                    :  (VEL_W+1)'(fpy[VEL_W+GAIN_W-1:GAIN_W]);
      end
      ST_VEL: begin
        vx_new <= sat_sum(SUM_W'(fricx) + SUM_W'(fx));
        vy_new <= sat_sum(SUM_W'(fricy) + SUM_W'(fy));
      end
      default: ;
    endcase
  end

  // output register, one item deep
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_go) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_slot     <= SLOT_W'(i_idx);
      out_pos_x    <= px_fin;
      out_pos_y    <= py_fin;
      out_vel_x    <= vx_fin;
      out_vel_y    <= vy_fin;
      last_of_tick <= (i_idx == IDX_W'(COUNT-1));
    end
  end

endmodule

@@ rtl/core/prs_checker.sv @@
// ----------------------------------------------------------------------------
// prs_checker
// port level checks of the particle repulsion block
// ----------------------------------------------------------------------------
`include "particle_repulsion_step_defines.svh"

module prs_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [prs_pkg::SLOT_W-1:0]           out_slot,
  input logic                                 last_of_tick
);
  import prs_pkg::*;

  `PRS_ASSERT_RST(a_reset_idle, rst |=> !out_valid && !in_stall)

  `PRS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_slot))

  `PRS_ASSERT(a_last_slot, out_valid && last_of_tick |-> out_slot == SLOT_W'(COUNT-1))

  // while a result short of the last is shown the block takes no new item
  `PRS_ASSERT(a_busy_mid_tick, out_valid && !last_of_tick |-> in_stall)

endmodule

bind particle_repulsion_step prs_checker u_prs_checker (.*);
